/* design/gzhs_pkg.sv */
// Shared types and constants of the gzip header stripper.
package gzhs_pkg;

  localparam int TRAILER_BYTES = 8;
  localparam int FILL_W = $clog2(TRAILER_BYTES + 1);

  localparam logic [7:0] MAGIC0 = 8'h1f;
  localparam logic [7:0] MAGIC1 = 8'h8b;
  localparam logic [7:0] METHOD_DEFLATE = 8'h08;
  localparam logic [7:0] FLAG_RESERVED = 8'hE0;
  localparam int FLAG_HCRC = 1;
  localparam int FLAG_EXTRA = 2;
  localparam int FLAG_NAME = 3;
  localparam int FLAG_COMMENT = 4;
  localparam logic [15:0] FIXED_BYTES = 16'd6;
  localparam logic [15:0] HCRC_BYTES = 16'd2;

  typedef enum logic [1:0] {
    ERR_OK     = 2'd0,
    ERR_MAGIC  = 2'd1,
    ERR_METHOD = 2'd2,
    ERR_SHORT  = 2'd3
  } err_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } item_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       finished;
    logic [1:0] error_code;
  } result_t;

  typedef struct packed {
    logic [7:0] data;
    logic       store;
    logic       last;
    logic       chk_fill;
    err_t       code;
  } mid_t;

endpackage

/* design/gzip_header_strip.sv */
// Top level of the gzip header stripper: parser, queue, trailer stage.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  input    | push / full        | item   (in_byte, is_last)
//  result   | empty / pop        | result (payload_valid, payload_byte,
//           |                    |         finished, error_code)
//
// One byte is taken per cycle while full is low and gives one result; a result
// passes through the two-entry queue and the result queue, both registered.
// Synchronous reset empties both queues and returns the parser to the first
// magic byte. A stalled result side fills the result queue, then the middle
// queue, and then raises full; each side stalls on its own.
module gzip_header_strip import gzhs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  output logic    full,
  input  item_t   item,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  mid_t cls, mid;
  logic mid_empty, mid_rd, take;

  assign take = push && !full;

  gzhs_front u_front (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (item),
    .cls  (cls)
  );

  gzhs_mid_queue u_mid (
    .clk     (clk),
    .rst     (rst),
    .wr      (push),
    .wr_data (cls),
    .full    (full),
    .rd      (mid_rd),
    .empty   (mid_empty),
    .rd_data (mid)
  );

  gzhs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .mid_empty (mid_empty),
    .mid       (mid),
    .mid_rd    (mid_rd),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

/* design/gzhs_front.sv */
// Header parser: classifies each accepted byte of the gzip member.
module gzhs_front import gzhs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  take,
  input  item_t item,
  output mid_t  cls
);

  typedef enum logic [3:0] {
    P_MAGIC0, P_MAGIC1, P_METHOD, P_FLAGS, P_FIXED, P_XLEN_LO, P_XLEN_HI,
    P_EXTRA, P_NAME, P_COMMENT, P_HCRC, P_PAYLOAD, P_DROP
  } phase_t;

  phase_t      phase, phase_next;
  logic [4:0]  flags, flags_next;
  logic [15:0] skip, skip_next;
  logic [7:0]  xlen_lo, xlen_lo_next;
  err_t        err_seen, err_seen_next;
  logic [15:0] skip_dec;

  function automatic phase_t enter_part(input logic [2:0] pos, input logic [4:0] f);
    phase_t p;
    if (pos <= 3'd0 && f[FLAG_EXTRA]) p = P_XLEN_LO;
    else if (pos <= 3'd1 && f[FLAG_NAME]) p = P_NAME;
    else if (pos <= 3'd2 && f[FLAG_COMMENT]) p = P_COMMENT;
    else if (pos <= 3'd3 && f[FLAG_HCRC]) p = P_HCRC;
    else p = P_PAYLOAD;
    return p;
  endfunction

  assign skip_dec = (skip != 16'd0) ? skip - 16'd1 : skip;

  always_comb begin
    phase_next = phase;
    flags_next = flags;
    skip_next = skip;
    xlen_lo_next = xlen_lo;
    err_seen_next = err_seen;
    case (phase)
      P_MAGIC0: begin
        if (item.in_byte != MAGIC0) begin
          err_seen_next = ERR_MAGIC;
          phase_next = P_DROP;
        end else phase_next = P_MAGIC1;
      end
      P_MAGIC1: begin
        if (item.in_byte != MAGIC1) begin
          err_seen_next = ERR_MAGIC;
          phase_next = P_DROP;
        end else phase_next = P_METHOD;
      end
      P_METHOD: begin
        if (item.in_byte != METHOD_DEFLATE) begin
          err_seen_next = ERR_METHOD;
          phase_next = P_DROP;
        end else phase_next = P_FLAGS;
      end
      P_FLAGS: begin
        if ((item.in_byte & FLAG_RESERVED) != 8'd0) begin
          err_seen_next = ERR_METHOD;
          phase_next = P_DROP;
        end else begin
          flags_next = item.in_byte[4:0];
          skip_next = FIXED_BYTES;
          phase_next = P_FIXED;
        end
      end
      P_FIXED: begin
        skip_next = skip_dec;
        if (skip_dec == 16'd0) phase_next = enter_part(3'd0, flags);
      end
      P_XLEN_LO: begin
        xlen_lo_next = item.in_byte;
        phase_next = P_XLEN_HI;
      end
      P_XLEN_HI: begin
        skip_next = {item.in_byte, xlen_lo};
        if ({item.in_byte, xlen_lo} == 16'd0) phase_next = enter_part(3'd1, flags);
        else phase_next = P_EXTRA;
      end
      P_EXTRA: begin
        skip_next = skip_dec;
        if (skip_dec == 16'd0) phase_next = enter_part(3'd1, flags);
      end
      P_NAME: begin
        if (item.in_byte == 8'd0) phase_next = enter_part(3'd2, flags);
      end
      P_COMMENT: begin
        if (item.in_byte == 8'd0) phase_next = enter_part(3'd3, flags);
      end
      P_HCRC: begin
        skip_next = skip_dec;
        if (skip_dec == 16'd0) phase_next = enter_part(3'd4, flags);
      end
      default: begin
      end
    endcase
    if (phase_next == P_HCRC && phase != P_HCRC) skip_next = HCRC_BYTES;
  end

  always_comb begin
    cls.data = item.in_byte;
    cls.store = (phase == P_PAYLOAD);
    cls.last = item.is_last;
    cls.chk_fill = 1'b0;
    cls.code = ERR_OK;
    if (item.is_last) begin
      if (phase_next == P_DROP) cls.code = err_seen_next;
      else if (phase_next != P_PAYLOAD) cls.code = ERR_SHORT;
      else cls.chk_fill = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_MAGIC0;
      flags <= '0;
      skip <= '0;
      xlen_lo <= '0;
      err_seen <= ERR_OK;
    end else if (take) begin
      if (item.is_last) begin
        phase <= P_MAGIC0;
        flags <= '0;
        skip <= '0;
        xlen_lo <= '0;
        err_seen <= ERR_OK;
      end else begin
        phase <= phase_next;
        flags <= flags_next;
        skip <= skip_next;
        xlen_lo <= xlen_lo_next;
        err_seen <= err_seen_next;
      end
    end
  end

endmodule

/* design/gzhs_mid_queue.sv */
// Two-entry queue of classified bytes between parser and trailer stage.
module gzhs_mid_queue import gzhs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  mid_t wr_data,
  output logic full,
  input  logic rd,
  output logic empty,
  output mid_t rd_data
);

  mid_t       mem [2];
  logic [1:0] count;
  logic       wr_ptr, rd_ptr;
  logic       do_wr, do_rd;

  assign full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (do_wr) wr_ptr <= !wr_ptr;
      if (do_rd) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

endmodule

/* design/gzhs_back.sv */
// Trailer delay line, end-of-member status and result queue.
module gzhs_back import gzhs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    mid_empty,
  input  mid_t    mid,
  output logic    mid_rd,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  logic [7:0]        line [TRAILER_BYTES];
  logic [FILL_W-1:0] fill, fill_next;
  result_t           res;
  result_t           oq [2];
  logic [1:0]        count;
  logic              wr_ptr, rd_ptr;
  logic              take, do_pop, line_full;

  assign take = !mid_empty && (count != 2'd2);
  assign mid_rd = take;
  assign line_full = (fill == FILL_W'(TRAILER_BYTES));

  always_comb begin
    fill_next = fill;
    if (mid.store && !line_full) fill_next = fill + FILL_W'(1);
    res.payload_valid = mid.store && line_full;
    res.payload_byte = (mid.store && line_full) ? line[0] : 8'd0;
    res.finished = mid.last;
    res.error_code = ERR_OK;
    if (mid.last) begin
      if (mid.chk_fill) begin
        res.error_code = (fill_next < FILL_W'(TRAILER_BYTES)) ? ERR_SHORT : ERR_OK;
      end else res.error_code = mid.code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (take) begin
      fill <= mid.last ? '0 : fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && mid.store) begin
      for (int k = 0; k < TRAILER_BYTES - 1; k++) line[k] <= line[k + 1];
      line[TRAILER_BYTES - 1] <= mid.data;
    end
  end

  assign empty = (count == 2'd0);
  assign do_pop = pop && !empty;
  assign result = oq[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (take) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, take} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (take) oq[wr_ptr] <= res;
  end

endmodule

/* design/gzhs_checker.sv */
// Port-level assertions for the gzip header stripper, bound to the top level.
module gzhs_checker import gzhs_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    push,
  input logic    full,
  input item_t   item,
  input logic    empty,
  input logic    pop,
  input result_t result
);

  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  a_err_only_last: assert property (@(posedge clk) disable iff (rst)
    !empty && !result.finished |-> result.error_code == ERR_OK)
    else $error("error code on a result that is not the last");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && !result.payload_valid |-> result.payload_byte == 8'd0)
    else $error("payload byte set without payload_valid");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("waiting result changed");

endmodule

bind gzip_header_strip gzhs_checker u_gzhs_checker (.*);
